// ===== rtl/pms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

   localparam int OP_W        = 2;
   localparam int STACK_W     = 3;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_SHOW = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_BAD_STACK = 2'd1;
   localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd2;
   localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd3;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/partitioned_multi_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none

// several lifo stacks sharing one element store, one fixed segment per stack
// req channel: one beat is one request (push, pop or display) on a one-based
//   stack; op code 3 is dropped with no response
// rsp channel: push and pop give one beat, display gives one beat per element
//   from top to bottom; rsp_tlast marks the final beat of a request
// errors (bad stack number, overflow, empty) give one beat with zero data
// push and error beats are registered straight into the output state; pop and
//   display beats first pass a store read (ST_READ), then the output register
// one request is in flight at a time; req_tready is high only when idle, so a
//   new request is not taken until the final beat of the last one is taken,
//   also while the receiver holds rsp_tready low
// the store has a single port, so each displayed element needs its own store read
// a stalled response beat holds steady until taken
// reset empties every stack; store contents are only read after being pushed
module partitioned_multi_stack
   import pms_pkg::*;
#(
   parameter int NUM_STACKS    = 4,
   parameter int SEGMENT_DEPTH = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // operation[1:0], stack_number[4:2], push_value[36:5], zero pad above
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // status[1:0], data_word[33:2], zero pad above
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                        rsp_tlast
);

   localparam int DEPTH = NUM_STACKS * SEGMENT_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PAD_W = RSP_TDATA_W - STATUS_W - DATA_W;

   logic [OP_W-1:0]     req_op;
   logic [STACK_W-1:0]  req_stack;
   logic [DATA_W-1:0]   req_value;
   logic [STATUS_W-1:0] rsp_status;
   logic [DATA_W-1:0]   rsp_data;
   mem_cmd_type         mem_cmd;
   logic [AW-1:0]       mem_addr;
   logic [DATA_W-1:0]   mem_wr_data;
   logic [DATA_W-1:0]   mem_rd_data;

   assign req_op    = req_tdata[OP_W-1:0];
   assign req_stack = req_tdata[OP_W+STACK_W-1:OP_W];
   assign req_value = req_tdata[OP_W+STACK_W+DATA_W-1:OP_W+STACK_W];

   assign rsp_tdata = {PAD_W'(0), rsp_data, rsp_status};

   pms_ctrl #(
      .NUM_STACKS    (NUM_STACKS),
      .SEGMENT_DEPTH (SEGMENT_DEPTH),
      .AW            (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_op),
      .req_stack   (req_stack),
      .req_value   (req_value),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_status),
      .rsp_data    (rsp_data),
      .rsp_last    (rsp_tlast),
      .mem_cmd     (mem_cmd),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   pms_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .cmd     (mem_cmd),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

// ===== rtl/pms_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pms_store
   import pms_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic              clock,
   input  wire mem_cmd_type       cmd,
   input  wire logic [AW-1:0]     addr,
   input  wire logic [DATA_W-1:0] wr_data,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pms_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pms_ctrl
   import pms_pkg::*;
#(
   parameter int NUM_STACKS    = 4,
   parameter int SEGMENT_DEPTH = 8,
   parameter int AW            = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [OP_W-1:0]     req_op,
   input  wire logic [STACK_W-1:0]  req_stack,
   input  wire logic [DATA_W-1:0]   req_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic      [DATA_W-1:0]   rsp_data,
   output logic                     rsp_last,
   output mem_cmd_type              mem_cmd,
   output logic      [AW-1:0]       mem_addr,
   output logic      [DATA_W-1:0]   mem_wr_data,
   input  wire logic [DATA_W-1:0]   mem_rd_data
);

   localparam int CW   = $clog2(SEGMENT_DEPTH + 1);
   localparam int SW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int SUMW = AW + CW;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic                last_ff, last_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [CW-1:0]       fill_ff [NUM_STACKS];

   logic [STACK_W-1:0]  stack_m1;
   logic [SW-1:0]       sidx;
   logic                stack_ok;
   logic [CW-1:0]       cnt;
   logic [AW-1:0]       base_now;
   logic [AW-1:0]       base_sel;
   logic [CW-1:0]       off_sel;
   logic [SUMW-1:0]     addr_sum;
   logic                fill_we;
   logic [CW-1:0]       fill_wval;
   logic                op_known;

   assign stack_m1 = req_stack - STACK_W'(1);
   assign sidx     = stack_m1[SW-1:0];
   assign stack_ok = (req_stack != '0) &&
                     ({1'b0, req_stack} <= (STACK_W + 1)'(NUM_STACKS));
   assign cnt      = fill_ff[sidx];
   assign base_now = AW'(SUMW'(sidx) * SUMW'(SEGMENT_DEPTH));
   assign op_known = (req_op == OP_PUSH) || (req_op == OP_POP) || (req_op == OP_SHOW);

   // shared address adder: segment base plus offset within the segment
   assign base_sel = (state_ff == ST_IDLE) ? base_now : base_ff;
   assign addr_sum = SUMW'(base_sel) + SUMW'(off_sel);
   assign mem_addr = addr_sum[AW-1:0];
   assign mem_wr_data = req_value;

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      data_in       = data_ff;
      last_in       = last_ff;
      idx_in        = idx_ff;
      base_in       = base_ff;
      off_sel       = '0;
      fill_we       = 1'b0;
      fill_wval     = cnt;
      mem_cmd.wr_en = 1'b0;
      mem_cmd.rd_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && op_known) begin
               base_in   = base_now;
               state_in  = ST_OUT;
               last_in   = 1'b1;
               data_in   = '0;
               idx_in    = '0;
               status_in = STS_OK;
               if (!stack_ok) begin
                  status_in = STS_BAD_STACK;
               end else begin
                  case (req_op)
                     OP_PUSH: begin
                        if (cnt == CW'(SEGMENT_DEPTH)) begin
                           status_in = STS_OVERFLOW;
                        end else begin
                           mem_cmd.wr_en = 1'b1;
                           off_sel       = cnt;
                           fill_we       = 1'b1;
                           fill_wval     = cnt + CW'(1);
                           data_in       = req_value;
                        end
                     end
                     OP_POP: begin
                        if (cnt == '0) begin
                           status_in = STS_EMPTY;
                        end else begin
                           mem_cmd.rd_en = 1'b1;
                           off_sel       = cnt - CW'(1);
                           fill_we       = 1'b1;
                           fill_wval     = cnt - CW'(1);
                           state_in      = ST_READ;
                        end
                     end
                     default: begin
                        // display walks from the top entry down to the bottom
                        if (cnt == '0) begin
                           status_in = STS_EMPTY;
                        end else begin
                           mem_cmd.rd_en = 1'b1;
                           off_sel       = cnt - CW'(1);
                           idx_in        = cnt - CW'(1);
                           state_in      = ST_READ;
                        end
                     end
                  endcase
               end
            end
         end
         ST_READ: begin
            status_in = STS_OK;
            data_in   = mem_rd_data;
            last_in   = (idx_ff == '0);
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (idx_ff != '0) begin
                  idx_in        = idx_ff - CW'(1);
                  off_sel       = idx_ff - CW'(1);
                  mem_cmd.rd_en = 1'b1;
                  state_in      = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < NUM_STACKS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (fill_we) begin
            fill_ff[sidx] <= fill_wval;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      data_ff   <= data_in;
      last_ff   <= last_in;
      idx_ff    <= idx_in;
      base_ff   <= base_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_OUT);
   assign rsp_status = status_ff;
   assign rsp_data   = data_ff;
   assign rsp_last   = last_ff;

   a_no_rw_same_cycle: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("store written and read in the same cycle");

   a_read_then_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_OUT))
      else $error("read data not presented after a read");

   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STS_OK)) |-> (rsp_data == '0) && rsp_last)
      else $error("error beat carries data or is not last");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      stack_ok |-> (cnt <= CW'(SEGMENT_DEPTH)))
      else $error("stack fill count above segment depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && stack_ok && (req_op == OP_PUSH) &&
       (cnt != CW'(SEGMENT_DEPTH))) |=> (fill_ff[$past(sidx)] == $past(cnt) + CW'(1)))
      else $error("push did not advance the fill count");

endmodule

`default_nettype wire
